@@ hw/rtl/set_assoc_lru_miss_counter_macros.svh @@
// assertion macros shared by the cache model rtl
`ifndef SET_ASSOC_LRU_MISS_COUNTER_MACROS_SVH
`define SET_ASSOC_LRU_MISS_COUNTER_MACROS_SVH

// a condition implies another in the same cycle
`define SALC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// a condition implies another in the next cycle
`define SALC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// constants and types shared by the set-associative cache model
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int LineOffsetBits = 6;
   localparam int Ways           = 12;
   localparam int Sets           = 4096;
   localparam int AddressBits    = 48;

   localparam int InBits   = 48;
   localparam int SetBits  = (Sets > 1) ? $clog2(Sets) : 1;
   localparam int SetShift = $clog2(Sets);
   localparam int TagBits  = AddressBits - LineOffsetBits - SetShift;
   localparam int WayBits  = 4;
   localparam int RankBits = 4;
   localparam int CntBits  = WayBits + 1;
   localparam int MissBits = 32;
   localparam int EntBits  = 1 + TagBits + RankBits;
   localparam int RowBits  = Ways * EntBits;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic            hit;
      logic [WayBits-1:0] way;
      logic            evicted;
   } outcome_type;

endpackage

@@ hw/rtl/salc_ram.sv @@
// ----------------------------------------------------------------------------
// salc_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/salc_update.sv @@
// ----------------------------------------------------------------------------
// salc_update
// tag compare, victim pick and lru rank update over one set row
// ----------------------------------------------------------------------------
module salc_update (
   input  logic [salc_pkg::RowBits-1:0] row,
   input  logic [salc_pkg::CntBits-1:0] filled,
   input  logic [salc_pkg::TagBits-1:0] tag,
   output logic [salc_pkg::RowBits-1:0] new_row,
   output logic [salc_pkg::CntBits-1:0] new_filled,
   output salc_pkg::outcome_type        outcome
);

   localparam int TB = salc_pkg::TagBits;
   localparam int RB = salc_pkg::RankBits;
   localparam int EB = salc_pkg::EntBits;

   logic [salc_pkg::Ways-1:0] match;
   logic [salc_pkg::Ways-1:0] is_old;
   logic [RB-1:0]             limit;
   logic [salc_pkg::WayBits-1:0] way;

   always_comb begin
      logic [RB-1:0] rk;
      logic [RB-1:0] sel_rank;
      logic [salc_pkg::WayBits-1:0] hway;
      logic [salc_pkg::WayBits-1:0] vway;
      logic found;
      logic vfound;
      hway = '0;
      vway = '0;
      found = 1'b0;
      vfound = 1'b0;
      sel_rank = '0;
      for (int i = 0; i < salc_pkg::Ways; i++) begin
         match[i]  = row[i*EB+EB-1] && (row[i*EB+RB +: TB] == tag);
         is_old[i] = row[i*EB+EB-1]
            && (row[i*EB +: RB] == RB'(filled - salc_pkg::CntBits'(1)));
      end
      for (int i = salc_pkg::Ways - 1; i >= 0; i--) begin
         if (match[i]) begin
            found = 1'b1;
            hway = salc_pkg::WayBits'(i);
         end
         if (is_old[i]) begin
            vfound = 1'b1;
            vway = salc_pkg::WayBits'(i);
         end
      end
      outcome.hit = found;
      outcome.evicted = 1'b0;
      new_filled = filled;
      if (found) begin
         way = hway;
      end else if (filled < salc_pkg::CntBits'(salc_pkg::Ways)) begin
         way = salc_pkg::WayBits'(filled);
         new_filled = filled + salc_pkg::CntBits'(1);
      end else begin
         way = vfound ? vway : '0;
         outcome.evicted = 1'b1;
      end
      outcome.way = way;
      sel_rank = '0;
      for (int i = 0; i < salc_pkg::Ways; i++) begin
         if (salc_pkg::WayBits'(i) == way) begin
            sel_rank = row[i*EB +: RB];
         end
      end
      // a fill ages every valid way
      if (!found && filled < salc_pkg::CntBits'(salc_pkg::Ways)) begin
         limit = RB'(filled);
      end else begin
         limit = sel_rank;
      end
      new_row = row;
      for (int i = 0; i < salc_pkg::Ways; i++) begin
         rk = row[i*EB +: RB];
         if (salc_pkg::WayBits'(i) == way) begin
            new_row[i*EB+EB-1] = 1'b1;
            new_row[i*EB+RB +: TB] = tag;
            new_row[i*EB +: RB] = '0;
         end else if (row[i*EB+EB-1] && rk < limit) begin
            new_row[i*EB +: RB] = rk + RB'(1);
         end
      end
   end

endmodule

@@ hw/rtl/set_assoc_lru_miss_counter.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_miss_counter
// set-associative cache model with true-lru replacement and miss count
// ----------------------------------------------------------------------------
// Each request first reads the set row from the set memory, then compares,
// updates and writes it back; no new address is taken while that update is
// in progress. The set memory holds one row per set with a
// valid bit, tag and lru rank per way; after reset a clearing pass walks all
// 4096 rows, one per cycle, before the first request is accepted. A response
// waits in an output register; while it is stalled no new request is taken,
// and a request is accepted again in the cycle that response transfers.
module set_assoc_lru_miss_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_byte_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [3:0]  rsp_way_used,
   output logic        rsp_evicted,
   output logic [31:0] rsp_miss_total
);

   `include "set_assoc_lru_miss_counter_macros.svh"

   localparam int SB = salc_pkg::SetBits;
   localparam int TB = salc_pkg::TagBits;
   localparam int CB = salc_pkg::CntBits;
   localparam int WB = CB + salc_pkg::RowBits;

   logic              clearing_ff, clearing_in;
   logic [SB-1:0]     clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [SB-1:0]     set_ff, set_in;
   logic [TB-1:0]     tag_ff, tag_in;
   logic [31:0]       miss_ff, miss_in;
   logic              ov_ff, ov_in;
   salc_pkg::outcome_type oc_ff, oc_in;
   logic [31:0]       omiss_ff, omiss_in;

   logic              accept;
   logic              wr_en;
   logic [SB-1:0]     addr;
   logic [WB-1:0]     wr_data, rd_data;
   logic [salc_pkg::RowBits-1:0] new_row;
   logic [CB-1:0]     new_filled;
   salc_pkg::outcome_type outcome;
   logic [salc_pkg::AddressBits-salc_pkg::LineOffsetBits-1:0] line;

   // result register must be free when the update completes
   assign req_stall = clearing_ff || busy_ff || (ov_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign line = req_byte_address[salc_pkg::AddressBits-1:salc_pkg::LineOffsetBits];

   salc_update u_update (
      .row        (rd_data[salc_pkg::RowBits-1:0]),
      .filled     (rd_data[WB-1:salc_pkg::RowBits]),
      .tag        (tag_ff),
      .new_row    (new_row),
      .new_filled (new_filled),
      .outcome    (outcome)
   );

   always_comb begin
      wr_en = 1'b0;
      addr = SB'(line);
      wr_data = {new_filled, new_row};
      if (clearing_ff) begin
         wr_en = 1'b1;
         addr = clr_ff;
         wr_data = '0;
      end else if (busy_ff) begin
         wr_en = 1'b1;
         addr = set_ff;
      end
   end

   salc_ram #(.Width(WB), .Depth(salc_pkg::Sets)) u_sets (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      clearing_in = clearing_ff;
      clr_in = clr_ff;
      busy_in = accept;
      set_in = accept ? SB'(line) : set_ff;
      tag_in = accept ? line[salc_pkg::AddressBits-salc_pkg::LineOffsetBits-1 -:
                             TB] : tag_ff;
      miss_in = miss_ff;
      ov_in = ov_ff && rsp_stall;
      oc_in = oc_ff;
      omiss_in = omiss_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + SB'(1);
         if (clr_ff == SB'(salc_pkg::Sets - 1)) begin
            clearing_in = 1'b0;
         end
      end
      if (busy_ff) begin
         if (!outcome.hit && miss_ff != 32'hFFFF_FFFF) begin
            miss_in = miss_ff + 32'd1;
         end
         ov_in = 1'b1;
         oc_in = outcome;
         omiss_in = (!outcome.hit && miss_ff != 32'hFFFF_FFFF) ?
                    miss_ff + 32'd1 : miss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
         busy_ff <= 1'b0;
         miss_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff <= clr_in;
         busy_ff <= busy_in;
         miss_ff <= miss_in;
         ov_ff <= ov_in;
      end
      set_ff <= set_in;
      tag_ff <= tag_in;
      oc_ff <= oc_in;
      omiss_ff <= omiss_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_hit = oc_ff.hit;
   assign rsp_way_used = oc_ff.way;
   assign rsp_evicted = oc_ff.evicted;
   assign rsp_miss_total = omiss_ff;

   `SALC_ASSERT_IMPLY(a_no_req_clearing, clock, reset, clearing_ff, !accept)
   `SALC_ASSERT_NEXT(a_update_follows, clock, reset, accept, busy_ff)
   `SALC_ASSERT_NEXT(a_rsp_after_update, clock, reset, busy_ff, rsp_valid)
   `SALC_ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted)

endmodule

@@ verif/set_assoc_lru_miss_counter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_miss_counter_tb
// self-checking bench for the set-associative lru cache model: addresses go in
// with random gaps and stalls. A true-lru cache predictor works out hit, way,
// eviction and miss count for every accepted address, and each response is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module set_assoc_lru_miss_counter_tb;

   localparam int CycleLimit = 400000;

   typedef struct {
      logic                         hit;
      logic [salc_pkg::WayBits-1:0] way;
      logic                         evicted;
      logic [31:0]                  miss_total;
   } lookup_result_type;

   class cache_scoreboard;
      logic [salc_pkg::TagBits-1:0]  tag_of   [int];
      logic [salc_pkg::RankBits-1:0] rank_of  [int];
      int                            filled   [int];
      logic [31:0]                   misses;
      lookup_result_type             expected_q[$];
      int                            errors;

      function new();
         misses = 0;
         errors = 0;
      endfunction

      // move a way to most recent, aging valid ways that were more recent than limit
      function void promote(int set_idx, int way, int limit, int count);
         int i;
         for (i = 0; i < count; i++) begin
            if (i != way && int'(rank_of[set_idx*16+i]) < limit) begin
               rank_of[set_idx*16+i] = rank_of[set_idx*16+i] +
                                       salc_pkg::RankBits'(1);
            end
         end
         rank_of[set_idx*16+way] = '0;
      endfunction

      function void note_access(logic [47:0] addr);
         int set_idx;
         int count;
         int i;
         logic [salc_pkg::TagBits-1:0] tag;
         lookup_result_type r;
         set_idx = int'(addr[salc_pkg::LineOffsetBits +: salc_pkg::SetShift]);
         tag = addr[salc_pkg::AddressBits-1 -: salc_pkg::TagBits];
         count = filled.exists(set_idx) ? filled[set_idx] : 0;
         r.hit = 1'b0;
         r.way = '0;
         r.evicted = 1'b0;
         for (i = 0; i < count; i++) begin
            if (!r.hit && tag_of[set_idx*16+i] == tag) begin
               r.hit = 1'b1;
               r.way = salc_pkg::WayBits'(i);
            end
         end
         if (r.hit) begin
            promote(set_idx, r.way, rank_of[set_idx*16+r.way], count);
         end else begin
            if (count < salc_pkg::Ways) begin
               r.way = salc_pkg::WayBits'(count);
               filled[set_idx] = count + 1;
               tag_of[set_idx*16+count] = tag;
               rank_of[set_idx*16+count] = salc_pkg::RankBits'(count);
               promote(set_idx, count, count, count + 1);
            end else begin
               r.evicted = 1'b1;
               for (i = 0; i < count; i++) begin
                  if (int'(rank_of[set_idx*16+i]) == count - 1) begin
                     r.way = salc_pkg::WayBits'(i);
                  end
               end
               tag_of[set_idx*16+r.way] = tag;
               promote(set_idx, r.way, rank_of[set_idx*16+r.way], count);
            end
            if (misses != 32'hFFFF_FFFF) misses++;
         end
         r.miss_total = misses;
         expected_q.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(logic hit, logic [3:0] way, logic evicted,
                          logic [31:0] miss_total);
         lookup_result_type e;
         if (expected_q.size() == 0) begin
            report("response transfer with no access pending");
            return;
         end
         e = expected_q.pop_front();
         if (hit !== e.hit) report($sformatf("hit %0b, want %0b", hit, e.hit));
         if (way !== e.way) report($sformatf("way %0d, want %0d", way, e.way));
         if (evicted !== e.evicted)
            report($sformatf("evicted %0b, want %0b", evicted, e.evicted));
         if (miss_total !== e.miss_total)
            report($sformatf("miss_total %0d, want %0d", miss_total, e.miss_total));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [47:0] req_byte_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hit;
   logic [3:0]  rsp_way_used;
   logic        rsp_evicted;
   logic [31:0] rsp_miss_total;

   cache_scoreboard sb;
   bit  no_idle;
   bit  hold_request;
   int  cycle_count;

   set_assoc_lru_miss_counter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_address (req_byte_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_evicted      (rsp_evicted),
      .rsp_miss_total   (rsp_miss_total)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random stall per transfer, plus one long hold-off
   initial begin : receiver
      int wait_left;
      wait_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_hit, rsp_way_used, rsp_evicted, rsp_miss_total);
            wait_left = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (hold_request) begin
            wait_left = 300;
            hold_request = 0;
         end
         if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_access(logic [47:0] addr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_address <= addr;
      do @(posedge clock); while (req_stall);
      sb.note_access(addr);
   endtask

   // mostly a few hot sets with a small tag pool so sets fill, hit and evict
   function automatic logic [47:0] pick_address();
      logic [47:0] a;
      int set_idx;
      a = 48'({$urandom, $urandom});
      if ($urandom_range(0, 9) < 7) begin
         set_idx = ($urandom_range(0, 4) == 0) ? salc_pkg::Sets - 1 : $urandom_range(0, 3);
         a[salc_pkg::LineOffsetBits +: salc_pkg::SetShift] =
            salc_pkg::SetShift'(set_idx);
         a[salc_pkg::AddressBits-1 -: salc_pkg::TagBits] = ($urandom_range(0, 3) == 0) ?
            {{(salc_pkg::TagBits-4){1'b1}}, 4'($urandom_range(0, 15))} :
            salc_pkg::TagBits'($urandom_range(0, 15));
      end
      return a;
   endfunction

   initial begin : stimulus
      int i;
      sb = new();
      cycle_count = 0;
      no_idle = 0;
      hold_request = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_address = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extremes and a second offset in the same line
      send_access(48'h0);
      send_access(48'hFFFF_FFFF_FFFF);
      send_access(48'h3F);
      send_access(48'hAAAA_AAAA_AAAA);
      send_access(48'h5555_5555_5555);
      // fill set 5 past its ways so the oldest line is replaced
      for (i = 0; i < salc_pkg::Ways + 2; i++) send_access({30'(i), 12'd5, 6'(i)});
      // the first two were evicted; tag 0 misses and evicts tag 2, 5 and 13 hit, 2 misses
      send_access({30'd0, 12'd5, 6'd0});
      send_access({30'd5, 12'd5, 6'd0});
      send_access({30'd13, 12'd5, 6'd0});
      send_access({30'd2, 12'd5, 6'd0});

      for (i = 0; i < 600; i++) begin
         if (i == 200) hold_request = 1;
         no_idle = (i >= 350 && i < 420);
         send_access(pick_address());
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
